// ===== rtl/mspi_pkg.sv =====
// ----------------------------------------------------------------------------
// mspi_pkg
// Shared types and constants for the motor speed/current PI step unit.
// ----------------------------------------------------------------------------
package mspi_pkg;

  localparam int DRIVE_LIMIT_DEF = 120;   // default upper drive bound
  localparam int SPEED_PER_PULSE = 6;
  localparam int SCALE_FRAC      = 16;    // acc Q.8 times scale Q8.8

  localparam int PULSE_W  = 10;
  localparam int READ_W   = 10;
  localparam int SPEED_W  = 13;
  localparam int ERR_W    = 14;
  localparam int CHANGE_W = 11;
  localparam int GAIN_W   = 16;
  localparam int ACC_W    = 40;
  localparam int SUM_W    = 32;
  localparam int DRIVE_W  = 8;
  localparam int MUL_A_W  = ACC_W + 1;
  localparam int MUL_B_W  = GAIN_W + 1;
  localparam int PROD_W   = MUL_A_W + MUL_B_W;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic signed [ACC_W-1:0] ACC_ONE = ACC_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SETPOINT    = 3'd0,
    REG_SPD_GAIN_N  = 3'd1,
    REG_SPD_GAIN_P  = 3'd2,
    REG_CUR_GAIN_N  = 3'd3,
    REG_CUR_GAIN_P  = 3'd4,
    REG_OUT_SCALE   = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    TERM_SPD_NOW  = 2'd0,
    TERM_SPD_PREV = 2'd1,
    TERM_CUR_NOW  = 2'd2,
    TERM_CUR_PREV = 2'd3
  } term_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_LOAD,
    OP_MUL_TERM,
    OP_ADD_TERM,
    OP_SAT,
    OP_MUL_SCALE,
    OP_DIV_INIT,
    OP_DIV_STEP,
    OP_DIV_LOAD,
    OP_LOWER
  } dp_op_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_ADD,
    S_SAT,
    S_MUL_CHK,
    S_CMP,
    S_DIV_INIT,
    S_DIV_STEP,
    S_DIV_LOAD,
    S_LOWER,
    S_MUL_DRV,
    S_DONE
  } state_t;

  typedef struct packed {
    dp_op_t op;
    term_t  term;
  } dp_ctrl_t;

  typedef struct packed {
    logic hi_clamp;   // accumulator times scale exceeds the drive limit
    logic div_last;   // final quotient bit in progress
  } dp_stat_t;

endpackage

// ===== rtl/mspi_ctrl.sv =====
// ----------------------------------------------------------------------------
// mspi_ctrl
// Sequencer that steps the shared multiplier and divider through one tick.
// ----------------------------------------------------------------------------
module mspi_ctrl
  import mspi_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_fire,
  input  logic     out_free,
  input  dp_stat_t stat,
  output dp_ctrl_t ctl,
  output logic     idle,
  output logic     out_load
);

  state_t state_r, state_nxt;
  term_t  term_r, term_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      term_r  <= TERM_SPD_NOW;
    end else begin
      state_r <= state_nxt;
      term_r  <= term_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    term_nxt  = term_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          state_nxt = S_MUL;
          term_nxt  = TERM_SPD_NOW;
        end
      end
      S_MUL:      state_nxt = S_ADD;
      S_ADD: begin
        if (term_r == TERM_CUR_PREV) begin
          state_nxt = S_SAT;
        end else begin
          state_nxt = S_MUL;
          term_nxt  = term_t'(term_r + 2'd1);
        end
      end
      S_SAT:      state_nxt = S_MUL_CHK;
      S_MUL_CHK:  state_nxt = S_CMP;
      S_CMP:      state_nxt = stat.hi_clamp ? S_DIV_INIT : S_LOWER;
      S_DIV_INIT: state_nxt = S_DIV_STEP;
      S_DIV_STEP: state_nxt = stat.div_last ? S_DIV_LOAD : S_DIV_STEP;
      S_DIV_LOAD: state_nxt = S_LOWER;
      S_LOWER:    state_nxt = S_MUL_DRV;
      S_MUL_DRV:  state_nxt = S_DONE;
      S_DONE:     state_nxt = out_free ? S_IDLE : S_DONE;
      default:    state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    ctl.term = term_r;
    ctl.op   = OP_NONE;
    idle     = 1'b0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        idle   = 1'b1;
        ctl.op = in_fire ? OP_LOAD : OP_NONE;
      end
      S_MUL:      ctl.op = OP_MUL_TERM;
      S_ADD:      ctl.op = OP_ADD_TERM;
      S_SAT:      ctl.op = OP_SAT;
      S_MUL_CHK:  ctl.op = OP_MUL_SCALE;
      S_CMP:      ctl.op = OP_NONE;
      S_DIV_INIT: ctl.op = OP_DIV_INIT;
      S_DIV_STEP: ctl.op = OP_DIV_STEP;
      S_DIV_LOAD: ctl.op = OP_DIV_LOAD;
      S_LOWER:    ctl.op = OP_LOWER;
      S_MUL_DRV:  ctl.op = OP_MUL_SCALE;
      S_DONE:     out_load = out_free;
      default:    ctl.op = OP_NONE;
    endcase
  end

endmodule

// ===== rtl/mspi_dp.sv =====
// ----------------------------------------------------------------------------
// mspi_dp
// Datapath: one shared signed multiplier, a term adder, a saturating
// accumulator update and a bit-serial restoring divider for the clamp.
// ----------------------------------------------------------------------------
module mspi_dp
  import mspi_pkg::*;
#(
  parameter int DRIVE_LIMIT = DRIVE_LIMIT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  dp_ctrl_t                   ctl,
  input  logic [PULSE_W-1:0]         pulse_count,
  input  logic signed [READ_W-1:0]   current_reading,
  input  logic [SPEED_W-1:0]         setpoint_speed,
  input  logic signed [GAIN_W-1:0]   speed_gain_now,
  input  logic signed [GAIN_W-1:0]   speed_gain_prev,
  input  logic signed [GAIN_W-1:0]   current_gain_now,
  input  logic signed [GAIN_W-1:0]   current_gain_prev,
  input  logic [GAIN_W-1:0]          output_scale,
  output dp_stat_t                   stat,
  output logic [DRIVE_W-1:0]         drive_level,
  output logic [SPEED_W-1:0]         measured_speed,
  output logic signed [ERR_W-1:0]    speed_error
);

  localparam int NUM_W = $clog2(DRIVE_LIMIT + 1) + SCALE_FRAC;
  localparam int CNT_W = $clog2(NUM_W);
  localparam logic [NUM_W-1:0] LIMIT_NUM = NUM_W'(DRIVE_LIMIT) << SCALE_FRAC;
  localparam logic signed [PROD_W-1:0] LIMIT_PROD = PROD_W'(LIMIT_NUM);

  // Per-tick working values.
  logic [SPEED_W-1:0]         speed_r;
  logic signed [ERR_W-1:0]    err_r;
  logic signed [CHANGE_W-1:0] change_r;
  logic signed [READ_W-1:0]   reading_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [SUM_W-1:0]    sum_r;
  logic [GAIN_W-1:0]          rem_r;
  logic [NUM_W-1:0]           quot_r;
  logic [CNT_W-1:0]           cnt_r;

  // Controller state carried between ticks.
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic signed [ERR_W-1:0]    last_err_r;
  logic signed [READ_W-1:0]   last_read_r;
  logic signed [CHANGE_W-1:0] last_change_r;

  logic [SPEED_W-1:0]         speed_nxt;
  logic signed [MUL_A_W-1:0]  mul_a;
  logic signed [MUL_B_W-1:0]  mul_b;
  logic signed [ACC_W:0]      acc_wide;
  logic [GAIN_W:0]            trial;
  logic                       q_bit;

  assign speed_nxt = SPEED_W'(pulse_count) * SPEED_W'(SPEED_PER_PULSE);

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    if (ctl.op == OP_MUL_SCALE) begin
      mul_a = {acc_r[ACC_W-1], acc_r};
      mul_b = {1'b0, output_scale};
    end else begin
      unique case (ctl.term)
        TERM_SPD_NOW: begin
          mul_a = {{(MUL_A_W-ERR_W){err_r[ERR_W-1]}}, err_r};
          mul_b = {speed_gain_now[GAIN_W-1], speed_gain_now};
        end
        TERM_SPD_PREV: begin
          mul_a = {{(MUL_A_W-ERR_W){last_err_r[ERR_W-1]}}, last_err_r};
          mul_b = {speed_gain_prev[GAIN_W-1], speed_gain_prev};
        end
        TERM_CUR_NOW: begin
          mul_a = {{(MUL_A_W-CHANGE_W){change_r[CHANGE_W-1]}}, change_r};
          mul_b = {current_gain_now[GAIN_W-1], current_gain_now};
        end
        TERM_CUR_PREV: begin
          mul_a = {{(MUL_A_W-CHANGE_W){last_change_r[CHANGE_W-1]}}, last_change_r};
          mul_b = {current_gain_prev[GAIN_W-1], current_gain_prev};
        end
        default: begin
          mul_a = '0;
          mul_b = '0;
        end
      endcase
    end
  end

  assign acc_wide = {acc_r[ACC_W-1], acc_r}
                  + {{(ACC_W+1-SUM_W){sum_r[SUM_W-1]}}, sum_r};

  assign trial = {rem_r, LIMIT_NUM[cnt_r]};
  assign q_bit = (trial >= {1'b0, output_scale});

  always_comb begin
    acc_nxt = acc_r;
    unique case (ctl.op)
      OP_SAT: begin
        // Two top bits that differ mean the 40-bit range was left.
        if (acc_wide[ACC_W] != acc_wide[ACC_W-1]) begin
          acc_nxt = acc_wide[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}}
                                    : {1'b0, {(ACC_W-1){1'b1}}};
        end else begin
          acc_nxt = acc_wide[ACC_W-1:0];
        end
      end
      OP_DIV_LOAD: acc_nxt = ACC_W'(quot_r);
      OP_LOWER:    acc_nxt = (acc_r < ACC_ONE) ? ACC_ONE : acc_r;
      default:     acc_nxt = acc_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r         <= '0;
      last_err_r    <= '0;
      last_read_r   <= '0;
      last_change_r <= '0;
    end else begin
      acc_r <= acc_nxt;
      if (ctl.op == OP_SAT) begin
        last_err_r    <= err_r;
        last_change_r <= change_r;
        last_read_r   <= reading_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (ctl.op)
      OP_LOAD: begin
        speed_r   <= speed_nxt;
        err_r     <= $signed({1'b0, setpoint_speed}) - $signed({1'b0, speed_nxt});
        change_r  <= CHANGE_W'(last_read_r) - CHANGE_W'(current_reading);
        reading_r <= current_reading;
        sum_r     <= '0;
      end
      OP_MUL_TERM, OP_MUL_SCALE: prod_r <= mul_a * mul_b;
      OP_ADD_TERM: sum_r <= sum_r + prod_r[SUM_W-1:0];
      OP_DIV_INIT: begin
        rem_r  <= '0;
        quot_r <= '0;
        cnt_r  <= CNT_W'(NUM_W - 1);
      end
      OP_DIV_STEP: begin
        rem_r  <= q_bit ? GAIN_W'(trial - {1'b0, output_scale}) : trial[GAIN_W-1:0];
        quot_r <= {quot_r[NUM_W-2:0], q_bit};
        cnt_r  <= cnt_r - CNT_W'(1);
      end
      default: begin
      end
    endcase
  end

  assign stat.hi_clamp = (output_scale != '0) && !acc_r[ACC_W-1] && (acc_r != '0)
                       && (prod_r > LIMIT_PROD);
  assign stat.div_last = (cnt_r == '0);

  // After the lower clamp the product is positive, so only the upper bits matter.
  assign drive_level = (prod_r[PROD_W-1:SCALE_FRAC+DRIVE_W] != '0)
                     ? {DRIVE_W{1'b1}} : prod_r[SCALE_FRAC+DRIVE_W-1:SCALE_FRAC];
  assign measured_speed = speed_r;
  assign speed_error    = err_r;

endmodule

// ===== rtl/motor_speed_current_pi_step_unit.sv =====
// ----------------------------------------------------------------------------
// motor_speed_current_pi_step_unit
// Cascaded incremental PI step for a motor drive, one transaction per tick.
// ----------------------------------------------------------------------------
// Usage:
//   The input stream carries one transaction per control tick: the encoder
//   pulse count and the averaged, midscale-removed current reading. Each
//   accepted transaction produces exactly one result transaction with the
//   drive level, its inverted DAC byte, the measured speed and speed error.
//   Gains, setpoint and output scale are written over the cfg channel, which
//   is always ready; write them only while no transaction is in flight.
//   When the upper clamp fires, the quotient DRIVE_LIMIT / scale is formed
//   one bit per cycle (23 steps for the default limit). All products go
//   through a single shared multiplier, one term at a time, so a new input is
//   taken only once the sequencer has finished the previous one. in_tready is
//   high only while the sequencer is idle; a result waiting in the output
//   register does not block the next input, but the following result
//   waits in the datapath until the receiver takes it. Synchronous reset
//   clears the accumulator, the stored previous error, reading and current
//   change, the config registers, the sequencer state and the output valid;
//   the other datapath registers and the output data are not reset.
// ----------------------------------------------------------------------------
module motor_speed_current_pi_step_unit
  import mspi_pkg::*;
#(
  parameter int DRIVE_LIMIT = DRIVE_LIMIT_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // pulse_count[9:0], current_reading[19:10], zero pad [23:20]
  input  logic [IN_DATA_W-1:0]  in_tdata,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // drive_level[7:0], dac_byte[15:8], measured_speed[28:16],
  // speed_error[42:29], zero pad [47:43]
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  logic [SPEED_W-1:0]        setpoint_r;
  logic signed [GAIN_W-1:0]  spd_gain_now_r, spd_gain_prev_r;
  logic signed [GAIN_W-1:0]  cur_gain_now_r, cur_gain_prev_r;
  logic [GAIN_W-1:0]         scale_r;

  logic                      out_valid_r;
  logic [OUT_DATA_W-1:0]     out_data_r;

  dp_ctrl_t                  ctl;
  dp_stat_t                  stat;
  logic                      idle, out_load, out_free, in_fire;
  logic [DRIVE_W-1:0]        drive_level;
  logic [SPEED_W-1:0]        measured_speed;
  logic signed [ERR_W-1:0]   speed_error;

  assign cfg_ready = 1'b1;
  assign in_tready = idle;
  assign in_fire   = in_tvalid && idle;
  assign out_free  = !out_valid_r || out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      setpoint_r      <= '0;
      spd_gain_now_r  <= '0;
      spd_gain_prev_r <= '0;
      cur_gain_now_r  <= '0;
      cur_gain_prev_r <= '0;
      scale_r         <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_SETPOINT:   setpoint_r      <= cfg_data[SPEED_W-1:0];
        REG_SPD_GAIN_N: spd_gain_now_r  <= cfg_data;
        REG_SPD_GAIN_P: spd_gain_prev_r <= cfg_data;
        REG_CUR_GAIN_N: cur_gain_now_r  <= cfg_data;
        REG_CUR_GAIN_P: cur_gain_prev_r <= cfg_data;
        REG_OUT_SCALE:  scale_r         <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  mspi_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_fire  (in_fire),
    .out_free (out_free),
    .stat     (stat),
    .ctl      (ctl),
    .idle     (idle),
    .out_load (out_load)
  );

  mspi_dp #(
    .DRIVE_LIMIT (DRIVE_LIMIT)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .ctl               (ctl),
    .pulse_count       (in_tdata[PULSE_W-1:0]),
    .current_reading   (in_tdata[PULSE_W+READ_W-1:PULSE_W]),
    .setpoint_speed    (setpoint_r),
    .speed_gain_now    (spd_gain_now_r),
    .speed_gain_prev   (spd_gain_prev_r),
    .current_gain_now  (cur_gain_now_r),
    .current_gain_prev (cur_gain_prev_r),
    .output_scale      (scale_r),
    .stat              (stat),
    .drive_level       (drive_level),
    .measured_speed    (measured_speed),
    .speed_error       (speed_error)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= OUT_DATA_W'({speed_error, measured_speed, ~drive_level, drive_level});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule

// ===== dv/tb_motor_speed_current_pi_step_unit.sv =====
// ----------------------------------------------------------------------------
// tb_motor_speed_current_pi_step_unit
// Self-checking bench for the cascaded speed/current PI step unit.
// ----------------------------------------------------------------------------
// A directed table covers the reset state, field extremes, both clamps, the
// wide drive case and writes to unused register indexes. Random phases then
// sweep setpoint, gains and scale, including a long integrator windup that
// drives the accumulator into saturation. Every result transaction is checked
// against a typed result or this bench's untimed model of the control step.
// ----------------------------------------------------------------------------
module tb_motor_speed_current_pi_step_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import mspi_pkg::*;

  localparam int CLK_PERIOD   = 12;
  localparam int TIMEOUT_CYC  = 800_000;
  localparam int SETTLE_CYC   = 100;
  localparam int MAX_REPORTS  = 10;
  localparam int IDLE_PCT     = 28;
  localparam int HOLD_AT      = 400;    // result count at which the long hold-off starts
  localparam int HOLD_CYC     = 300;
  localparam int CALM_FIRST   = 600;    // no idling on either side inside this window
  localparam int CALM_LAST    = 800;
  localparam int WINDUP_ITEMS = 1100;
  localparam int CLAMP_ITEMS  = 20;
  localparam int RAND_PHASES  = 6;
  localparam int PHASE_ITEMS  = 35;

  // Indexes beyond the register file; writes there must be ignored.
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 3'd7;

  localparam longint ACC_MAX   = (64'sd1 <<< (ACC_W - 1)) - 1;
  localparam longint ACC_MIN   = -(64'sd1 <<< (ACC_W - 1));
  localparam longint ACC_FLOOR = longint'(ACC_ONE);
  localparam longint LIMIT_NUM = longint'(DRIVE_LIMIT_DEF) <<< SCALE_FRAC;

  typedef struct packed {
    logic [DRIVE_W-1:0] drive;
    logic [DRIVE_W-1:0] dac;
    logic [SPEED_W-1:0] speed;
    logic [ERR_W-1:0]   err;
  } drive_result_t;

  typedef struct {
    bit                       is_cfg;
    logic [CFG_IDX_W-1:0]     idx;
    logic [CFG_DATA_W-1:0]    value;
    logic [PULSE_W-1:0]       pulses;
    logic [READ_W-1:0]        reading;
    bit                       typed;
    drive_result_t            want;
  } dir_row_t;

  logic                  clk;
  logic                  rst_n;
  logic                  in_tvalid;
  logic                  in_tready;
  logic [IN_DATA_W-1:0]  in_tdata;    // pulse_count[9:0], current_reading[19:10], pad
  logic                  out_tvalid;
  logic                  out_tready;
  logic [OUT_DATA_W-1:0] out_tdata;   // drive[7:0], dac[15:8], speed[28:16], err[42:29], pad
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  // Model copy of the registers and loop state.
  logic [SPEED_W-1:0]       set_speed_q;
  logic signed [GAIN_W-1:0] gain_spd_now, gain_spd_prev, gain_cur_now, gain_cur_prev;
  logic [GAIN_W-1:0]        scale_q;
  longint                   acc_q;
  int                       prev_err_q, prev_read_q, prev_change_q;

  drive_result_t drive_q[$];
  dir_row_t      dir_rows[$];
  drive_result_t want_res, got_res;
  int            items_sent, results_seen, mismatches;
  int            hold_left;
  bit            hold_done;

  motor_speed_current_pi_step_unit uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  initial begin
    #(CLK_PERIOD * TIMEOUT_CYC);
    $display("CHECKS FAILED");
    $finish;
  end

  function automatic drive_result_t pi_step_predict(logic [PULSE_W-1:0] pulses,
                                                    logic [READ_W-1:0] reading);
    int            speed, err, change, rd;
    longint        sum, acc, drive;
    drive_result_t r;
    rd     = int'($signed(reading));
    speed  = int'(pulses) * SPEED_PER_PULSE;
    err    = int'(set_speed_q) - speed;
    change = prev_read_q - rd;
    sum = longint'(gain_spd_now) * err + longint'(gain_spd_prev) * prev_err_q
        + longint'(gain_cur_now) * change + longint'(gain_cur_prev) * prev_change_q;
    acc = acc_q + sum;
    if (acc > ACC_MAX) acc = ACC_MAX;
    if (acc < ACC_MIN) acc = ACC_MIN;
    prev_err_q    = err;
    prev_change_q = change;
    prev_read_q   = rd;
    // The floor at 1.0 is applied after the upper clamp, so it wins when the
    // limit divided by the scale falls below one.
    if (scale_q != 0 && acc > 0 && acc * longint'(scale_q) > LIMIT_NUM)
      acc = LIMIT_NUM / longint'(scale_q);
    if (acc < ACC_FLOOR) acc = ACC_FLOOR;
    acc_q = acc;
    drive = (acc * longint'(scale_q)) >>> SCALE_FRAC;
    if (drive > 255) drive = 255;
    r.drive = DRIVE_W'(drive);
    r.dac   = ~r.drive;
    r.speed = SPEED_W'(speed);
    r.err   = ERR_W'(err);
    return r;
  endfunction

  function automatic void apply_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    case (idx)
      REG_SETPOINT:   set_speed_q   = SPEED_W'(value);
      REG_SPD_GAIN_N: gain_spd_now  = value;
      REG_SPD_GAIN_P: gain_spd_prev = value;
      REG_CUR_GAIN_N: gain_cur_now  = value;
      REG_CUR_GAIN_P: gain_cur_prev = value;
      REG_OUT_SCALE:  scale_q       = value;
      default: ;
    endcase
  endfunction

  function automatic void row_cfg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    dir_row_t r;
    r        = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.value  = value;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_item(logic [PULSE_W-1:0] pulses, logic [READ_W-1:0] reading);
    dir_row_t r;
    r         = '{default: '0};
    r.pulses  = pulses;
    r.reading = reading;
    dir_rows.push_back(r);
  endfunction

  function automatic void row_known(logic [PULSE_W-1:0] pulses, logic [READ_W-1:0] reading,
                                    int drive, int dac, int speed, int err);
    dir_row_t r;
    r            = '{default: '0};
    r.pulses     = pulses;
    r.reading    = reading;
    r.typed      = 1'b1;
    r.want.drive = DRIVE_W'(drive);
    r.want.dac   = DRIVE_W'(dac);
    r.want.speed = SPEED_W'(speed);
    r.want.err   = ERR_W'(err);
    dir_rows.push_back(r);
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(3))
      0:       return $urandom_range(1) ? 16'h7FFF : 16'h8000;
      1:       return CFG_DATA_W'($urandom);
      2:       return CFG_DATA_W'(int'($urandom_range(128)) - 64);
      default: return CFG_DATA_W'(int'($urandom_range(1200)) - 600);
    endcase
  endfunction

  task automatic send_item(logic [PULSE_W-1:0] pulses, logic [READ_W-1:0] reading,
                           bit typed, drive_result_t want);
    drive_result_t pred;
    if (!(items_sent >= CALM_FIRST && items_sent < CALM_LAST) &&
        $urandom_range(99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 24)) @(posedge clk);
    end
    in_tdata  <= {{(IN_DATA_W - PULSE_W - READ_W){1'b0}}, reading, pulses};
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    pred = pi_step_predict(pulses, reading);
    // Rows with a hand-written result are checked against that, not the model.
    drive_q.push_back(typed ? want : pred);
    items_sent++;
  endtask

  // Registers may only change with nothing in flight.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0 || !in_tready || out_tvalid);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_reg(idx, value);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic run_random(int count, bit windup);
    logic [PULSE_W-1:0] pulses;
    logic [READ_W-1:0]  reading;
    int                 p;
    for (int n = 0; n < count; n++) begin
      p = int'(set_speed_q) / SPEED_PER_PULSE + int'($urandom_range(40)) - 20;
      if (p < 0) p = 0;
      if (p > 1023) p = 1023;
      if (windup)
        pulses = PULSE_W'($urandom_range(3));
      else
        case ($urandom_range(7))
          0:       pulses = $urandom_range(1) ? '1 : '0;
          1, 2, 3: pulses = PULSE_W'(p);
          default: pulses = PULSE_W'($urandom);
        endcase
      case ($urandom_range(7))
        0:       reading = $urandom_range(1) ? 10'h1FF : 10'h200;
        default: reading = READ_W'($urandom);
      endcase
      send_item(pulses, reading, 1'b0, '0);
    end
  endtask

  task automatic write_random_config();
    logic [CFG_DATA_W-1:0] setpoint, scale;
    case ($urandom_range(3))
      0:       setpoint = '0;
      1:       setpoint = 16'd8191;
      default: setpoint = CFG_DATA_W'($urandom_range(8191));
    endcase
    case ($urandom_range(5))
      0:       scale = '0;
      1:       scale = 16'hFFFF;
      2:       scale = 16'd1;
      default: scale = CFG_DATA_W'($urandom_range(64, 4096));
    endcase
    write_reg(REG_SETPOINT, setpoint);
    write_reg(REG_SPD_GAIN_N, pick_gain());
    write_reg(REG_SPD_GAIN_P, pick_gain());
    write_reg(REG_CUR_GAIN_N, pick_gain());
    write_reg(REG_CUR_GAIN_P, pick_gain());
    write_reg(REG_OUT_SCALE, scale);
  endtask

  // Result side: random back-pressure, one long hold-off, and the checks.
  always @(posedge clk) begin
    if (out_tvalid && out_tready) begin
      got_res.drive = out_tdata[7:0];
      got_res.dac   = out_tdata[15:8];
      got_res.speed = out_tdata[28:16];
      got_res.err   = out_tdata[42:29];
      results_seen++;
      if (drive_q.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected result transaction: drive %0d dac %0d speed %0d err %0d",
                   got_res.drive, got_res.dac, got_res.speed, $signed(got_res.err));
      end else begin
        want_res = drive_q.pop_front();
        if (got_res.drive !== want_res.drive || got_res.dac !== want_res.dac ||
            got_res.speed !== want_res.speed || got_res.err !== want_res.err) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("result %0d mismatch: exp drive %0d dac %0d speed %0d err %0d, %s",
                     results_seen, want_res.drive, want_res.dac, want_res.speed,
                     $signed(want_res.err),
                     $sformatf("got drive %0d dac %0d speed %0d err %0d", got_res.drive,
                               got_res.dac, got_res.speed, $signed(got_res.err)));
        end
      end
    end
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left--;
      out_tready <= 1'b0;
    end else if (results_seen == HOLD_AT && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYC;
      out_tready <= 1'b0;
    end else begin
      out_tready <= (results_seen >= CALM_FIRST && results_seen < CALM_LAST) ||
                    $urandom_range(99) >= IDLE_PCT;
    end
  end

  initial begin
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    cfg_valid  <= 1'b0;
    cfg_index  <= '0;
    cfg_data   <= '0;
    set_speed_q   = '0;
    gain_spd_now  = '0;
    gain_spd_prev = '0;
    gain_cur_now  = '0;
    gain_cur_prev = '0;
    scale_q       = '0;
    acc_q         = 0;
    prev_err_q    = 0;
    prev_read_q   = 0;
    prev_change_q = 0;
    items_sent    = 0;

    // Reset values: all gains and the scale are zero, so the drive stays off.
    row_known(10'd0, 10'sd0, 0, 255, 0, 0);
    row_known(10'd1023, -10'sd512, 0, 255, 6138, -6138);
    row_known(10'd1023, 10'sd511, 0, 255, 6138, -6138);
    row_known(10'd0, -10'sd1, 0, 255, 0, 0);
    row_cfg(REG_SETPOINT, 16'd8191);
    row_known(10'd0, 10'sd0, 0, 255, 0, 8191);
    // Largest scale: the upper clamp falls below one and the floor wins; the
    // product then saturates the drive byte.
    row_cfg(REG_OUT_SCALE, 16'hFFFF);
    row_known(10'd5, 10'sd0, 255, 0, 30, 8161);
    row_cfg(REG_OUT_SCALE, 16'd256);
    row_known(10'd100, 10'sd0, 1, 254, 600, 7591);
    row_cfg(REG_OUT_SCALE, 16'd1);
    row_known(10'd1023, 10'sd0, 0, 255, 6138, 2053);
    row_cfg(REG_SPD_GAIN_N, 16'h7FFF);
    row_cfg(REG_SPD_GAIN_P, 16'h8000);
    row_cfg(REG_CUR_GAIN_N, 16'h8000);
    row_cfg(REG_CUR_GAIN_P, 16'h7FFF);
    row_cfg(REG_OUT_SCALE, 16'd256);
    row_item(10'd0, 10'sd511);
    row_item(10'd0, -10'sd512);
    row_item(10'd1023, 10'sd511);
    row_item(10'd1023, -10'sd512);
    row_item(10'd0, 10'sd0);
    row_item(10'd512, -10'sd1);
    row_item(10'd341, 10'sd256);
    row_cfg(REG_SETPOINT, 16'd0);
    row_item(10'd1023, 10'sd0);
    row_item(10'd1023, 10'sd0);
    row_cfg(REG_SPARE_A, 16'hFFFF);
    row_cfg(REG_SPARE_B, 16'h1234);
    row_item(10'd7, 10'sd100);
    row_cfg(REG_OUT_SCALE, 16'hFFFF);
    row_item(10'd0, 10'sd0);

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      if (dir_rows[i].is_cfg) begin
        if (i == 0 || !dir_rows[i-1].is_cfg) wait_idle();
        write_reg(dir_rows[i].idx, dir_rows[i].value);
      end else begin
        send_item(dir_rows[i].pulses, dir_rows[i].reading, dir_rows[i].typed,
                  dir_rows[i].want);
      end
    end

    // Windup: full positive speed gains with no scale, so nothing clamps from
    // above and the accumulator climbs into saturation.
    wait_idle();
    write_reg(REG_SETPOINT, 16'd8191);
    write_reg(REG_SPD_GAIN_N, 16'h7FFF);
    write_reg(REG_SPD_GAIN_P, 16'h7FFF);
    write_reg(REG_CUR_GAIN_N, CFG_DATA_W'(int'($urandom_range(128)) - 64));
    write_reg(REG_CUR_GAIN_P, CFG_DATA_W'(int'($urandom_range(128)) - 64));
    write_reg(REG_OUT_SCALE, '0);
    run_random(WINDUP_ITEMS, 1'b1);

    // Turning the scale on with a saturated accumulator forces the upper clamp.
    wait_idle();
    write_reg(REG_OUT_SCALE, 16'hFFFF);
    run_random(CLAMP_ITEMS, 1'b0);

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      wait_idle();
      write_random_config();
      run_random(PHASE_ITEMS, 1'b0);
    end

    in_tvalid <= 1'b0;
    do @(posedge clk); while (drive_q.size() != 0);
    repeat (SETTLE_CYC) @(posedge clk);
    if (mismatches == 0 && drive_q.size() == 0)
      $display("ALL CHECKS PASSED");
    else
      $display("CHECKS FAILED");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/mspi_pkg.sv
rtl/mspi_ctrl.sv
rtl/mspi_dp.sv
rtl/motor_speed_current_pi_step_unit.sv
dv/tb_motor_speed_current_pi_step_unit.sv
